>>> src/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Types, constants and datapath step functions for the circle collision
// response core.
// ----------------------------------------------------------------------------
package ccr_pkg;

	localparam int CFG_W = 17;
	localparam logic [CFG_W-1:0] REST_RST = 17'd65536;
	localparam logic [17:0] K_ONE = 18'd65536;

	localparam int SQ_N = 32;
	localparam int MD_N = 25;
	localparam int ND_N = 29;
	localparam int IT_N = SQ_N + 1 + ND_N;
	localparam int BK_N = 12;

	localparam int unsigned NSH = 28;
	localparam int unsigned FSH = 24;
	localparam int unsigned KSH = 16;

	localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
	localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

	typedef struct packed {
		logic signed [31:0] apx;
		logic signed [31:0] apy;
		logic signed [31:0] avx;
		logic signed [31:0] avy;
		logic signed [31:0] bpx;
		logic signed [31:0] bpy;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
	} circ_t;

	typedef struct packed {
		logic  collided;
		circ_t res;
	} out_t;

	typedef struct packed {
		circ_t       o;
		logic        hit;
		logic        sx;
		logic        sy;
		logic [31:0] adx;
		logic [31:0] ady;
		logic [31:0] rsum;
		logic [31:0] msum;
		logic [63:0] d2;
		logic [33:0] sq_rem;
		logic [31:0] sq_root;
		logic [55:0] ma_num;
		logic [55:0] mb_num;
		logic [31:0] ma_rem;
		logic [31:0] mb_rem;
		logic [24:0] ma_q;
		logic [24:0] mb_q;
		logic [31:0] len;
		logic [31:0] depth;
		logic [24:0] fa;
		logic [24:0] fb;
		logic [60:0] nx_num;
		logic [60:0] ny_num;
		logic [31:0] nx_rem;
		logic [31:0] ny_rem;
		logic [28:0] nx_q;
		logic [28:0] ny_q;
	} it_t;

	typedef struct packed {
		circ_t              o;
		circ_t              res;
		logic               hit;
		logic signed [29:0] nx;
		logic signed [29:0] ny;
		logic [24:0]        fa;
		logic [24:0]        fb;
		logic [31:0]        depth;
		logic signed [61:0] pa1;
		logic signed [61:0] pa2;
		logic signed [61:0] pb1;
		logic signed [61:0] pb2;
		logic [56:0]        sap;
		logic [56:0]        sbp;
		logic signed [62:0] suma;
		logic signed [62:0] sumb;
		logic [32:0]        sa;
		logic [32:0]        sb;
		logic signed [33:0] vna;
		logic signed [33:0] vnb;
		logic signed [62:0] pxa;
		logic signed [62:0] pya;
		logic signed [62:0] pxb;
		logic signed [62:0] pyb;
		logic signed [34:0] delta;
		logic signed [35:0] rxa;
		logic signed [35:0] rya;
		logic signed [35:0] rxb;
		logic signed [35:0] ryb;
		logic signed [59:0] ta;
		logic signed [59:0] tb;
		logic signed [35:0] ua;
		logic signed [35:0] ub;
		logic signed [54:0] wa;
		logic signed [54:0] wb;
		logic signed [39:0] dva;
		logic signed [39:0] dvb;
		logic signed [69:0] qax;
		logic signed [69:0] qay;
		logic signed [69:0] qbx;
		logic signed [69:0] qby;
		logic signed [41:0] rqax;
		logic signed [41:0] rqay;
		logic signed [41:0] rqbx;
		logic signed [41:0] rqby;
	} bk_t;

	// Shift right by sh with rounding to nearest, ties away from zero.
	function automatic logic signed [71:0] rnd_sh(input logic signed [71:0] v,
			input int unsigned sh);
		logic [71:0] mag;
		logic [71:0] q;
		mag = v[71] ? 72'(-v) : 72'(v);
		q = (mag + (72'd1 << (sh - 1))) >> sh;
		return v[71] ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		logic signed [71:0] r;
		r = v;
		if (v > S32_MAX) begin
			r = S32_MAX;
		end else if (v < S32_MIN) begin
			r = S32_MIN;
		end
		return r[31:0];
	endfunction

	// One digit of the square root, two radicand bits per step.
	function automatic it_t sq_step(input it_t p, input int k);
		it_t         n;
		logic [35:0] t;
		logic [35:0] trial;
		n = p;
		t = {p.sq_rem, p.d2[63-2*k -: 2]};
		trial = {2'b00, p.sq_root, 2'b01};
		if (t >= trial) begin
			n.sq_rem = 34'(t - trial);
			n.sq_root = {p.sq_root[30:0], 1'b1};
		end else begin
			n.sq_rem = t[33:0];
			n.sq_root = {p.sq_root[30:0], 1'b0};
		end
		return n;
	endfunction

	// One quotient bit of both mass ratios.
	function automatic it_t md_step(input it_t p, input int k);
		it_t         n;
		logic [32:0] ta;
		logic [32:0] tb;
		logic [32:0] dv;
		n = p;
		dv = {1'b0, p.msum};
		ta = {p.ma_rem, p.ma_num[24-k]};
		tb = {p.mb_rem, p.mb_num[24-k]};
		if (ta >= dv) begin
			n.ma_rem = 32'(ta - dv);
			n.ma_q = {p.ma_q[23:0], 1'b1};
		end else begin
			n.ma_rem = ta[31:0];
			n.ma_q = {p.ma_q[23:0], 1'b0};
		end
		if (tb >= dv) begin
			n.mb_rem = 32'(tb - dv);
			n.mb_q = {p.mb_q[23:0], 1'b1};
		end else begin
			n.mb_rem = tb[31:0];
			n.mb_q = {p.mb_q[23:0], 1'b0};
		end
		return n;
	endfunction

	function automatic it_t len_step(input it_t p);
		it_t n;
		n = p;
		n.len = p.sq_root;
		n.depth = p.rsum - p.sq_root;
		n.fa = (p.msum == 32'd0) ? 25'd0 : p.ma_q;
		n.fb = (p.msum == 32'd0) ? 25'd0 : p.mb_q;
		n.nx_num = {1'b0, p.adx, 28'd0} + 61'(p.sq_root >> 1);
		n.ny_num = {1'b0, p.ady, 28'd0} + 61'(p.sq_root >> 1);
		n.nx_rem = n.nx_num[60:29];
		n.ny_rem = n.ny_num[60:29];
		n.nx_q = '0;
		n.ny_q = '0;
		return n;
	endfunction

	// One quotient bit of both normal components.
	function automatic it_t nd_step(input it_t p, input int j);
		it_t         n;
		logic [32:0] tx;
		logic [32:0] ty;
		logic [32:0] dv;
		n = p;
		dv = {1'b0, p.len};
		tx = {p.nx_rem, p.nx_num[28-j]};
		ty = {p.ny_rem, p.ny_num[28-j]};
		if (tx >= dv) begin
			n.nx_rem = 32'(tx - dv);
			n.nx_q = {p.nx_q[27:0], 1'b1};
		end else begin
			n.nx_rem = tx[31:0];
			n.nx_q = {p.nx_q[27:0], 1'b0};
		end
		if (ty >= dv) begin
			n.ny_rem = 32'(ty - dv);
			n.ny_q = {p.ny_q[27:0], 1'b1};
		end else begin
			n.ny_rem = ty[31:0];
			n.ny_q = {p.ny_q[27:0], 1'b0};
		end
		return n;
	endfunction

	function automatic bk_t bk_init(input it_t p);
		bk_t         n;
		logic [28:0] mx;
		logic [28:0] my;
		n = '0;
		mx = (p.len == 32'd0) ? 29'd0 : p.nx_q;
		my = (p.len == 32'd0) ? 29'd0 : p.ny_q;
		n.o = p.o;
		n.res = p.o;
		n.hit = p.hit;
		n.fa = p.fa;
		n.fb = p.fb;
		n.depth = p.depth;
		n.nx = p.sx ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
		n.ny = p.sy ? -$signed({1'b0, my}) : $signed({1'b0, my});
		return n;
	endfunction

	function automatic bk_t bk_step(input bk_t p, input int k, input logic [17:0] kq);
		bk_t n;
		n = p;
		case (k)
			1: begin
				n.pa1 = 62'(p.o.avx * p.nx);
				n.pa2 = 62'(p.o.avy * p.ny);
				n.pb1 = 62'(p.o.bvx * p.nx);
				n.pb2 = 62'(p.o.bvy * p.ny);
				n.sap = 57'(p.depth * p.fb);
				n.sbp = 57'(p.depth * p.fa);
			end
			2: begin
				n.suma = 63'(p.pa1) + 63'(p.pa2);
				n.sumb = 63'(p.pb1) + 63'(p.pb2);
				n.sa = 33'(rnd_sh($signed(72'(p.sap)), FSH));
				n.sb = 33'(rnd_sh($signed(72'(p.sbp)), FSH));
			end
			3: begin
				n.vna = 34'(rnd_sh(72'(p.suma), NSH));
				n.vnb = 34'(rnd_sh(72'(p.sumb), NSH));
				n.pxa = 63'($signed({1'b0, p.sa}) * p.nx);
				n.pya = 63'($signed({1'b0, p.sa}) * p.ny);
				n.pxb = 63'($signed({1'b0, p.sb}) * p.nx);
				n.pyb = 63'($signed({1'b0, p.sb}) * p.ny);
			end
			4: begin
				n.delta = 35'(p.vnb) - 35'(p.vna);
				n.rxa = 36'(rnd_sh(72'(p.pxa), NSH));
				n.rya = 36'(rnd_sh(72'(p.pya), NSH));
				n.rxb = 36'(rnd_sh(72'(p.pxb), NSH));
				n.ryb = 36'(rnd_sh(72'(p.pyb), NSH));
			end
			5: begin
				n.ta = 60'(p.delta * $signed({1'b0, p.fb}));
				n.tb = 60'(p.delta * $signed({1'b0, p.fa}));
				n.res.apx = sat32(72'(p.o.apx) - 72'(p.rxa));
				n.res.apy = sat32(72'(p.o.apy) - 72'(p.rya));
				n.res.bpx = sat32(72'(p.o.bpx) + 72'(p.rxb));
				n.res.bpy = sat32(72'(p.o.bpy) + 72'(p.ryb));
			end
			6: begin
				n.ua = 36'(rnd_sh(72'(p.ta), FSH));
				n.ub = 36'(rnd_sh(72'(p.tb), FSH));
			end
			7: begin
				n.wa = 55'(p.ua * $signed({1'b0, kq}));
				n.wb = 55'(p.ub * $signed({1'b0, kq}));
			end
			8: begin
				n.dva = 40'(rnd_sh(72'(p.wa), KSH));
				n.dvb = 40'(rnd_sh(72'(p.wb), KSH));
			end
			9: begin
				n.qax = 70'(p.dva * p.nx);
				n.qay = 70'(p.dva * p.ny);
				n.qbx = 70'(p.dvb * p.nx);
				n.qby = 70'(p.dvb * p.ny);
			end
			10: begin
				n.rqax = 42'(rnd_sh(72'(p.qax), NSH));
				n.rqay = 42'(rnd_sh(72'(p.qay), NSH));
				n.rqbx = 42'(rnd_sh(72'(p.qbx), NSH));
				n.rqby = 42'(rnd_sh(72'(p.qby), NSH));
			end
			11: begin
				n.res.avx = sat32(72'(p.o.avx) + 72'(p.rqax));
				n.res.avy = sat32(72'(p.o.avy) + 72'(p.rqay));
				n.res.bvx = sat32(72'(p.o.bvx) - 72'(p.rqbx));
				n.res.bvy = sat32(72'(p.o.bvy) - 72'(p.rqby));
				if (!p.hit) begin
					n.res = p.o;
				end
			end
			default: begin
				n = p;
			end
		endcase
		return n;
	endfunction

endpackage

>>> src/circle_collision_response_core.sv
// ----------------------------------------------------------------------------
// circle_collision_response_core
// Resolves a collision between two circles: overlap test, unit normal,
// restitution impulse and mass-weighted separation, all in Q16.16.
// ----------------------------------------------------------------------------
// The pipeline length from an input transaction to out_valid is set by the
// 32-step square root and the 29-step normal divider in the pipeline.
// Throughput: one transaction per cycle; a two-entry output queue absorbs
// output stalls and the pipeline halts only while that queue is full.
// Reset clears all valid bits and the queue and sets restitution to 1.0.
module circle_collision_response_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [31:0]         a_pos_x,
	input  logic signed [31:0]         a_pos_y,
	input  logic signed [31:0]         a_vel_x,
	input  logic signed [31:0]         a_vel_y,
	input  logic [30:0]                a_radius,
	input  logic [30:0]                a_mass,
	input  logic signed [31:0]         b_pos_x,
	input  logic signed [31:0]         b_pos_y,
	input  logic signed [31:0]         b_vel_x,
	input  logic signed [31:0]         b_vel_y,
	input  logic [30:0]                b_radius,
	input  logic [30:0]                b_mass,
	input  logic                       cfg_we,
	input  logic [ccr_pkg::CFG_W-1:0]  cfg_wdata,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       collided,
	output logic signed [31:0]         new_a_pos_x,
	output logic signed [31:0]         new_a_pos_y,
	output logic signed [31:0]         new_a_vel_x,
	output logic signed [31:0]         new_a_vel_y,
	output logic signed [31:0]         new_b_pos_x,
	output logic signed [31:0]         new_b_pos_y,
	output logic signed [31:0]         new_b_vel_x,
	output logic signed [31:0]         new_b_vel_y
);
	import ccr_pkg::*;

	logic [CFG_W-1:0] restitution_q;
	logic [17:0]      kq;

	logic             en;
	logic             push;
	logic             pop;

	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic [IT_N-1:0]  vit_s;
	logic [BK_N-1:0]  vbk_s;

	circ_t              o_s1;
	logic               sx_s1;
	logic               sy_s1;
	logic [32:0]        adx_s1;
	logic [32:0]        ady_s1;
	logic [31:0]        rsum_s1;
	logic [31:0]        msum_s1;
	logic [30:0]        am_s1;
	logic [30:0]        bm_s1;

	circ_t              o_s2;
	logic               sx_s2;
	logic               sy_s2;
	logic [31:0]        adx_s2;
	logic [31:0]        ady_s2;
	logic               lt_s2;
	logic [63:0]        dx2_s2;
	logic [63:0]        dy2_s2;
	logic [63:0]        r2_s2;
	logic [31:0]        rsum_s2;
	logic [31:0]        msum_s2;
	logic [30:0]        am_s2;
	logic [30:0]        bm_s2;

	it_t                ini_d;
	it_t                ini_s3;
	it_t                it_d [IT_N];
	it_t                it_s [IT_N];
	bk_t                bk_d [BK_N];
	bk_t                bk_s [BK_N];

	logic signed [32:0] dx_c;
	logic signed [32:0] dy_c;

	out_t               fifo_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	out_t               head;

	assign kq = K_ONE + 18'(restitution_q);
	assign en = (cnt_q != 2'd2);
	assign in_ready = en;
	assign push = en && vbk_s[BK_N-1];
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= REST_RST;
		end else if (cfg_we) begin
			restitution_q <= cfg_wdata;
		end
	end

	assign dx_c = 33'(b_pos_x) - 33'(a_pos_x);
	assign dy_c = 33'(b_pos_y) - 33'(a_pos_y);

	always_ff @(posedge clk) begin
		if (en) begin
			o_s1 <= '{a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y};
			sx_s1 <= dx_c[32];
			sy_s1 <= dy_c[32];
			adx_s1 <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
			ady_s1 <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
			rsum_s1 <= 32'(a_radius) + 32'(b_radius);
			msum_s1 <= 32'(a_mass) + 32'(b_mass);
			am_s1 <= a_mass;
			bm_s1 <= b_mass;

			o_s2 <= o_s1;
			sx_s2 <= sx_s1;
			sy_s2 <= sy_s1;
			adx_s2 <= adx_s1[31:0];
			ady_s2 <= ady_s1[31:0];
			lt_s2 <= (adx_s1 < {1'b0, rsum_s1}) && (ady_s1 < {1'b0, rsum_s1});
			dx2_s2 <= 64'(adx_s1[31:0]) * 64'(adx_s1[31:0]);
			dy2_s2 <= 64'(ady_s1[31:0]) * 64'(ady_s1[31:0]);
			r2_s2 <= 64'(rsum_s1) * 64'(rsum_s1);
			rsum_s2 <= rsum_s1;
			msum_s2 <= msum_s1;
			am_s2 <= am_s1;
			bm_s2 <= bm_s1;

			ini_s3 <= ini_d;
		end
	end

	always_comb begin
		ini_d = '0;
		ini_d.o = o_s2;
		ini_d.sx = sx_s2;
		ini_d.sy = sy_s2;
		ini_d.adx = adx_s2;
		ini_d.ady = ady_s2;
		ini_d.rsum = rsum_s2;
		ini_d.msum = msum_s2;
		ini_d.hit = lt_s2 && (({1'b0, dx2_s2} + {1'b0, dy2_s2}) < {1'b0, r2_s2});
		ini_d.d2 = dx2_s2 + dy2_s2;
		ini_d.ma_num = {1'b0, am_s2, 24'd0} + 56'(msum_s2 >> 1);
		ini_d.mb_num = {1'b0, bm_s2, 24'd0} + 56'(msum_s2 >> 1);
		ini_d.ma_rem = 32'(ini_d.ma_num[55:25]);
		ini_d.mb_rem = 32'(ini_d.mb_num[55:25]);
	end

	for (genvar k = 0; k < IT_N; k++) begin : g_it
		it_t prev_w;
		if (k == 0) begin : g_first
			assign prev_w = ini_s3;
		end else begin : g_next
			assign prev_w = it_s[k-1];
		end

		always_comb begin
			it_t n;
			n = prev_w;
			if (k < SQ_N) begin
				n = sq_step(n, k);
			end
			if (k < MD_N) begin
				n = md_step(n, k);
			end
			if (k == SQ_N) begin
				n = len_step(n);
			end
			if (k > SQ_N) begin
				n = nd_step(n, k - SQ_N - 1);
			end
			it_d[k] = n;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s[k] <= it_d[k];
			end
		end
	end

	for (genvar k = 0; k < BK_N; k++) begin : g_bk
		if (k == 0) begin : g_first
			assign bk_d[k] = bk_init(it_s[IT_N-1]);
		end else begin : g_next
			assign bk_d[k] = bk_step(bk_s[k-1], k, kq);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				bk_s[k] <= bk_d[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vit_s <= '0;
			vbk_s <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vit_s <= {vit_s[IT_N-2:0], v_s3};
			vbk_s <= {vbk_s[BK_N-2:0], vit_s[IT_N-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{bk_s[BK_N-1].hit, bk_s[BK_N-1].res};
		end
	end

	assign head = fifo_q[rd_ptr_q];
	assign out_valid = (cnt_q != 2'd0);
	assign collided = head.collided;
	assign new_a_pos_x = head.res.apx;
	assign new_a_pos_y = head.res.apy;
	assign new_a_vel_x = head.res.avx;
	assign new_a_vel_y = head.res.avy;
	assign new_b_pos_x = head.res.bpx;
	assign new_b_pos_y = head.res.bpy;
	assign new_b_vel_x = head.res.bvx;
	assign new_b_vel_y = head.res.bvy;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted transaction did not enter the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> ($stable(vit_s) && $stable(vbk_s)))
		else $error("pipeline moved while stalled");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vbk_s[0] && bk_s[0].hit) |->
		(bk_s[0].nx <= 30'sd268435456 && bk_s[0].nx >= -30'sd268435456 &&
		bk_s[0].ny <= 30'sd268435456 && bk_s[0].ny >= -30'sd268435456))
		else $error("normal component exceeds unit range");

endmodule

>>> tb/tb_circle_collision_response_checker.sv
// ----------------------------------------------------------------------------
// tb_circle_collision_response_checker
// Watches the input, output and configuration ports of the collision core.
// It computes the expected response of every accepted pair in wide integer
// arithmetic and compares each output transaction with the oldest pending one.
// ----------------------------------------------------------------------------
module tb_circle_collision_response_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic signed [31:0]        a_pos_x,
	input  logic signed [31:0]        a_pos_y,
	input  logic signed [31:0]        a_vel_x,
	input  logic signed [31:0]        a_vel_y,
	input  logic [30:0]               a_radius,
	input  logic [30:0]               a_mass,
	input  logic signed [31:0]        b_pos_x,
	input  logic signed [31:0]        b_pos_y,
	input  logic signed [31:0]        b_vel_x,
	input  logic signed [31:0]        b_vel_y,
	input  logic [30:0]               b_radius,
	input  logic [30:0]               b_mass,
	input  logic                      cfg_we,
	input  logic [ccr_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      collided,
	input  logic signed [31:0]        new_a_pos_x,
	input  logic signed [31:0]        new_a_pos_y,
	input  logic signed [31:0]        new_a_vel_x,
	input  logic signed [31:0]        new_a_vel_y,
	input  logic signed [31:0]        new_b_pos_x,
	input  logic signed [31:0]        new_b_pos_y,
	input  logic signed [31:0]        new_b_vel_x,
	input  logic signed [31:0]        new_b_vel_y,
	output int                        pending,
	output int                        failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;

	localparam wide_t NORM_ONE = 128'sd268435456;
	localparam wide_t FRAC_ONE = 128'sd16777216;
	localparam wide_t K_UNIT = 128'sd65536;

	ccr_pkg::out_t response_queue[$];
	logic [ccr_pkg::CFG_W-1:0] restitution_q;

	function automatic wide_t round_div(input wide_t num, input wide_t den);
		wide_t mag;
		wide_t q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic wide_t floor_sqrt(input logic [63:0] v);
		logic [63:0] acc;
		logic [63:0] rem;
		logic [63:0] b;
		acc = '0;
		rem = v;
		b = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= acc + b) begin
				rem = rem - (acc + b);
				acc = (acc >> 1) + b;
			end else begin
				acc = acc >> 1;
			end
			b = b >> 2;
		end
		return wide_t'(acc);
	endfunction

	function automatic logic signed [31:0] clamp32(input wide_t v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic ccr_pkg::out_t resolve_collision(input ccr_pkg::circ_t c,
			input logic [30:0] ar, input logic [30:0] am, input logic [30:0] br,
			input logic [30:0] bm, input logic [ccr_pkg::CFG_W-1:0] rest);
		ccr_pkg::out_t o;
		wide_t apx, apy, avx, avy, bpx, bpy, bvx, bvy;
		wide_t dx, dy, rsum, msum, d2, len, nx, ny, fa, fb, kq;
		wide_t vna, vnb, delta, dva, dvb, depth, sa, sb;
		apx = wide_t'(c.apx); apy = wide_t'(c.apy);
		avx = wide_t'(c.avx); avy = wide_t'(c.avy);
		bpx = wide_t'(c.bpx); bpy = wide_t'(c.bpy);
		bvx = wide_t'(c.bvx); bvy = wide_t'(c.bvy);
		dx = bpx - apx;
		dy = bpy - apy;
		rsum = wide_t'(ar) + wide_t'(br);
		msum = wide_t'(am) + wide_t'(bm);
		d2 = dx * dx + dy * dy;
		o.collided = (d2 < rsum * rsum);
		o.res = c;
		if (o.collided) begin
			len = floor_sqrt(d2[63:0]);
			nx = 0;
			ny = 0;
			fa = 0;
			fb = 0;
			if (len != 0) begin
				nx = round_div(dx * NORM_ONE, len);
				ny = round_div(dy * NORM_ONE, len);
			end
			if (msum != 0) begin
				fa = round_div(wide_t'(am) * FRAC_ONE, msum);
				fb = round_div(wide_t'(bm) * FRAC_ONE, msum);
			end
			kq = K_UNIT + wide_t'(rest);
			vna = round_div(avx * nx + avy * ny, NORM_ONE);
			vnb = round_div(bvx * nx + bvy * ny, NORM_ONE);
			delta = vnb - vna;
			dva = round_div(round_div(delta * fb, FRAC_ONE) * kq, K_UNIT);
			dvb = round_div(round_div(delta * fa, FRAC_ONE) * kq, K_UNIT);
			o.res.avx = clamp32(avx + round_div(dva * nx, NORM_ONE));
			o.res.avy = clamp32(avy + round_div(dva * ny, NORM_ONE));
			o.res.bvx = clamp32(bvx - round_div(dvb * nx, NORM_ONE));
			o.res.bvy = clamp32(bvy - round_div(dvb * ny, NORM_ONE));
			depth = rsum - len;
			sa = round_div(depth * fb, FRAC_ONE);
			sb = round_div(depth * fa, FRAC_ONE);
			o.res.apx = clamp32(apx - round_div(sa * nx, NORM_ONE));
			o.res.apy = clamp32(apy - round_div(sa * ny, NORM_ONE));
			o.res.bpx = clamp32(bpx + round_div(sb * nx, NORM_ONE));
			o.res.bpy = clamp32(bpy + round_div(sb * ny, NORM_ONE));
		end
		return o;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s is %h, predicted %h", $realtime, field, got, want);
		failures++;
	endtask

	initial begin
		failures = 0;
		pending = 0;
		restitution_q = ccr_pkg::REST_RST;
	end

	always @(posedge clk or negedge arst_n) begin
		ccr_pkg::circ_t c;
		ccr_pkg::out_t want;
		if (!arst_n) begin
			restitution_q = ccr_pkg::REST_RST;
		end else begin
			if (cfg_we) begin
				restitution_q = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				c = '{a_pos_x, a_pos_y, a_vel_x, a_vel_y,
					b_pos_x, b_pos_y, b_vel_x, b_vel_y};
				response_queue.push_back(resolve_collision(c, a_radius, a_mass,
					b_radius, b_mass, restitution_q));
			end
			if (out_valid && out_ready) begin
				if (response_queue.size() == 0) begin
					$display("%0t: output transaction with nothing pending", $realtime);
					failures++;
				end else begin
					want = response_queue.pop_front();
					if (collided !== want.collided)
						report_mismatch("collided", 32'(collided), 32'(want.collided));
					if (new_a_pos_x !== want.res.apx)
						report_mismatch("new_a_pos_x", new_a_pos_x, want.res.apx);
					if (new_a_pos_y !== want.res.apy)
						report_mismatch("new_a_pos_y", new_a_pos_y, want.res.apy);
					if (new_a_vel_x !== want.res.avx)
						report_mismatch("new_a_vel_x", new_a_vel_x, want.res.avx);
					if (new_a_vel_y !== want.res.avy)
						report_mismatch("new_a_vel_y", new_a_vel_y, want.res.avy);
					if (new_b_pos_x !== want.res.bpx)
						report_mismatch("new_b_pos_x", new_b_pos_x, want.res.bpx);
					if (new_b_pos_y !== want.res.bpy)
						report_mismatch("new_b_pos_y", new_b_pos_y, want.res.bpy);
					if (new_b_vel_x !== want.res.bvx)
						report_mismatch("new_b_vel_x", new_b_vel_x, want.res.bvx);
					if (new_b_vel_y !== want.res.bvy)
						report_mismatch("new_b_vel_y", new_b_vel_y, want.res.bvy);
				end
			end
			pending = response_queue.size();
		end
	end

endmodule

>>> tb/tb_circle_collision_response_core.sv
// ----------------------------------------------------------------------------
// tb_circle_collision_response_core
// Drives circle pairs into the collision core under random idling on both
// sides, across several restitution settings, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_circle_collision_response_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
		logic [30:0]        ar, am, br, bm;
	} pair_t;

	logic clk, arst_n, in_valid, in_ready, cfg_we, out_valid, out_ready, collided;
	logic signed [31:0] a_pos_x, a_pos_y, a_vel_x, a_vel_y;
	logic signed [31:0] b_pos_x, b_pos_y, b_vel_x, b_vel_y;
	logic [30:0] a_radius, a_mass, b_radius, b_mass;
	logic [ccr_pkg::CFG_W-1:0] cfg_wdata;
	logic signed [31:0] new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y;
	logic signed [31:0] new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y;
	int pending, failures;
	bit gapless, hold_req;

	circle_collision_response_core u_top (.*);
	tb_circle_collision_response_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("circle_collision_response_core: mismatch");
		$finish;
	end

	function automatic logic signed [31:0] rand_span(input int unsigned bits);
		logic signed [31:0] v;
		v = $urandom;
		return v >>> (32 - bits);
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int unsigned mode;
		mode = $urandom_range(0, 9);
		p.apx = $urandom; p.apy = $urandom; p.avx = $urandom; p.avy = $urandom;
		p.bpx = $urandom; p.bpy = $urandom; p.bvx = $urandom; p.bvy = $urandom;
		p.ar = 31'($urandom); p.br = 31'($urandom);
		p.am = 31'($urandom); p.bm = 31'($urandom);
		if (mode < 7) begin
			p.apx = rand_span(26); p.apy = rand_span(26);
			p.bpx = p.apx + rand_span(22); p.bpy = p.apy + rand_span(22);
			p.avx = rand_span(24); p.avy = rand_span(24);
			p.bvx = rand_span(24); p.bvy = rand_span(24);
			p.ar = 31'($urandom_range(0, 1 << 21)); p.br = 31'($urandom_range(0, 1 << 21));
			p.am = 31'($urandom_range(1, 1 << 24)); p.bm = 31'($urandom_range(1, 1 << 24));
		end else if (mode == 7) begin
			p.bpx = p.apx + rand_span(30); p.bpy = p.apy + rand_span(30);
			p.ar = 31'($urandom_range(1 << 29, 31'h7fffffff));
		end
		return p;
	endfunction

	task automatic send_pair(input pair_t p);
		int unsigned gap;
		gap = gapless ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		a_pos_x <= p.apx; a_pos_y <= p.apy; a_vel_x <= p.avx; a_vel_y <= p.avy;
		b_pos_x <= p.bpx; b_pos_y <= p.bpy; b_vel_x <= p.bvx; b_vel_y <= p.bvy;
		a_radius <= p.ar; a_mass <= p.am; b_radius <= p.br; b_mass <= p.bm;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_restitution(input logic [ccr_pkg::CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned gap;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = gapless ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && !hold_req);
		end
	end

	initial begin
		pair_t p;
		pair_t directed[$];
		logic [ccr_pkg::CFG_W-1:0] settings[5];
		arst_n = 1'b0;
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		{a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y} <= '0;
		{a_radius, a_mass, b_radius, b_mass} <= '0;
		gapless = 1'b0;
		hold_req = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases: no overlap, zero radii, coincident centers, zero masses,
		// extreme fields and overlaps large enough to saturate.
		p = '{0, 0, 65536, 0, 32'sd200000, 0, -65536, 0, 65536, 65536, 65536, 65536};
		directed.push_back(p);
		p.bpx = 32'sd100000;
		directed.push_back(p);
		p.ar = 0; p.br = 0; p.bpx = 0;
		directed.push_back(p);
		p.ar = 1; p.bpy = 5;
		directed.push_back(p);
		p.ar = 65536; p.bpy = 0;
		directed.push_back(p);
		p.bpx = 32'sd30000; p.bpy = -32'sd20000; p.am = 0; p.bm = 0;
		directed.push_back(p);
		p.am = 31'h7fffffff; p.bm = 1;
		directed.push_back(p);
		p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
		directed.push_back(p);
		p.bpx = 32'sh7ffffff0; p.bpy = 32'sh7fffff00;
		directed.push_back(p);
		p = '{32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000100, 0,
			32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 1, 31'h7fffffff, 31'h7fffffff};
		directed.push_back(p);
		p = '{0, 0, 0, 0, 1, 1, 0, 0, 1, 1, 1, 1};
		directed.push_back(p);
		p = '{-32'sd1000, 32'sd500, 32'sd7000000, -32'sd9000000, 32'sd1000, -32'sd500,
			-32'sd8000000, 32'sd6000000, 32'sd3000, 32'sd5000, 32'sd3000, 32'sd4000};
		directed.push_back(p);
		foreach (directed[i]) send_pair(directed[i]);
		drain();

		settings = '{17'd0, 17'd131071, 17'd32768, 17'd65536, 17'd0};
		settings[4] = 17'($urandom_range(0, 131071));
		foreach (settings[s]) begin
			write_restitution(settings[s]);
			foreach (directed[i]) if (i % 4 == s % 4) send_pair(directed[i]);
			gapless = (s == 1);
			for (int i = 0; i < 200; i++) begin
				if (s == 2 && i == 50) hold_req = 1'b1;
				if (s == 3 && i == 100) drain();
				send_pair(random_pair());
			end
			gapless = 1'b0;
			drain();
		end

		if (failures == 0) begin
			$display("circle_collision_response_core: match");
		end else begin
			$display("circle_collision_response_core: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
src/ccr_pkg.sv
src/circle_collision_response_core.sv
tb/tb_circle_collision_response_checker.sv
tb/tb_circle_collision_response_core.sv
